// ===== design/tlhs_pkg.sv =====
`timescale 1ns / 1ps

package tlhs_pkg;

    // Operation codes carried in the input tuser field.
    typedef enum logic [1:0] {
        FUNC_RESET = 2'd0,
        FUNC_OFFER = 2'd1,
        FUNC_READ  = 2'd2,
        FUNC_NONE  = 2'd3
    } func_t;

    // Configuration register indexes.
    localparam logic CFG_STEP_INTERVAL = 1'b0;
    localparam logic CFG_TRACK_HEIGHT  = 1'b1;

    localparam int STEP_W   = 20;
    localparam int TRACK_W  = 10;
    localparam int LEVEL_W  = 7;
    localparam int FILLED_W = 6;
    localparam int CFG_W    = 20;

    localparam logic [STEP_W-1:0]  STEP_RESET  = 20'd1000;
    localparam logic [TRACK_W-1:0] TRACK_RESET = 10'd0;

    localparam logic [LEVEL_W-1:0] FULL_LEVEL = 7'd100;

    // Rounding offset and reciprocal of the divisor 100 (ceil(2^24 / 100)).
    localparam int               PROD_W       = TRACK_W + LEVEL_W;
    localparam logic [PROD_W:0]  HALF_DIVISOR = 18'd50;
    localparam int               RECIP_SHIFT  = 24;
    localparam logic [17:0]      RECIP_100    = 18'd167773;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_ADV,
        S_RD,
        S_MUL,
        S_DIVQ,
        S_DONE
    } state_t;

endpackage

// ===== design/tlhs_ram.sv =====
`timescale 1ns / 1ps

module tlhs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== design/tlhs_scale.sv =====
`timescale 1ns / 1ps

module tlhs_scale
    import tlhs_pkg::*;
(
    input  logic               clk,
    input  logic [LEVEL_W-1:0] level,
    input  logic [TRACK_W-1:0] track,
    output logic [TRACK_W-1:0] pixels
);

    logic [PROD_W-1:0]   prod_reg;
    logic                zero_reg;
    logic                zero2_reg;
    logic [TRACK_W-1:0]  quot_reg;
    logic [PROD_W:0]     rounded;
    logic [PROD_W+18:0]  recip_prod;

    // Division by 100 as a multiply by the reciprocal; exact for all products in range.
    assign rounded    = {1'b0, prod_reg} + HALF_DIVISOR;
    assign recip_prod = rounded * RECIP_100;

    always_ff @(posedge clk)
    begin
        prod_reg  <= track * level;
        zero_reg  <= (track == '0) || (level == '0);
        quot_reg  <= recip_prod[RECIP_SHIFT +: TRACK_W];
        zero2_reg <= zero_reg;
    end

    always_comb
    begin
        if (zero2_reg)
        begin
            pixels = '0;
        end
        else if (quot_reg == '0)
        begin
            pixels = TRACK_W'(1);
        end
        else
        begin
            pixels = quot_reg;
        end
    end

endmodule

// ===== design/timed_level_history_strip_top.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Handshake                     Payload
// s_axis    in         s_axis_tvalid / s_axis_tready tdata: now_time, level, column; tuser: func
// m_axis    out        m_axis_tvalid / m_axis_tready tdata: bar_level, bar_pixels, filled; tuser: ok
// cfg       in         cfg_we (no back-pressure)     cfg_index, cfg_wdata
//
// Each item is handled alone. Its result is loaded into the result register in S_DONE,
// reached from S_EXEC for a reset, a refused offer, an unused code or a read past the fill
// count, through S_ADV for a taken offer (the second deadline check runs on the advanced
// deadline), and through S_RD, S_MUL and S_DIVQ for a read, set by the registered read of the
// bar memory and the two registered stages of the pixel scaling multiply. S_DONE waits while
// the result side stalls; the next item is taken only back in S_IDLE, after that load.
// No clearing pass follows reset: the fill count alone marks which columns hold data.
// A stalled result register holds the finished item while the next one is accepted.

module timed_level_history_strip_top
    import tlhs_pkg::*;
#(
    parameter int BARS = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    // [31:0] now_time, [39:32] level, [44:40] column, [47:45] zero
    input  logic [47:0]        s_axis_tdata,
    // [1:0] func
    input  logic [1:0]         s_axis_tuser,
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    // [6:0] bar_level, [16:7] bar_pixels, [22:17] filled, [23] zero
    output logic [23:0]        m_axis_tdata,
    // [0] ok
    output logic               m_axis_tuser,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [CFG_W-1:0]   cfg_wdata
);

    localparam int AW = $clog2(BARS);
    localparam int FW = $clog2(BARS + 1);
    // Common width for column arithmetic against the ring pointer and fill count.
    localparam int XW = ((AW > 5) ? AW : 5) + 1;
    localparam logic [XW-1:0] BARS_X = XW'(BARS);
    localparam logic [AW-1:0] LAST_ADDR = AW'(BARS - 1);
    localparam logic [FW-1:0] FULL_FILL = FW'(BARS);

    state_t state_reg, state_next;

    logic [STEP_W-1:0]  step_reg;
    logic [TRACK_W-1:0] track_reg;

    logic [1:0]   func_reg;
    logic [31:0]  now_reg;
    logic [7:0]   level_in_reg;
    logic [4:0]   col_reg;

    logic [AW-1:0] head_reg, head_next;
    logic [FW-1:0] fill_reg, fill_next;
    logic [31:0]   deadline_reg, deadline_next;

    logic               res_ok_reg, res_ok_next;
    logic [LEVEL_W-1:0] res_level_reg, res_level_next;
    logic [TRACK_W-1:0] res_pix_reg, res_pix_next;

    logic               out_valid_reg, out_valid_next;
    logic               out_ok_reg;
    logic [LEVEL_W-1:0] out_level_reg;
    logic [TRACK_W-1:0] out_pix_reg;
    logic [FILLED_W-1:0] out_filled_reg;

    logic               ram_we, ram_re;
    logic [AW-1:0]      ram_waddr, ram_raddr;
    logic [LEVEL_W-1:0] ram_wdata, ram_rdata;
    logic [TRACK_W-1:0] scaled;

    logic               in_fire, out_free, load_out;
    logic [31:0]        step_ext;
    logic [31:0]        diff_now;
    logic               reached;
    logic [AW-1:0]      head_inc;
    logic [XW-1:0]      head_x, col_x, fill_x;
    logic [XW-1:0]      read_addr_x;
    logic               col_valid;
    logic [LEVEL_W-1:0] level_clamped;
    logic [FW+FILLED_W-1:0] fill_wide;

    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign out_free = !out_valid_reg || m_axis_tready;
    assign load_out = (state_reg == S_DONE) && out_free;

    assign s_axis_tready = (state_reg == S_IDLE);

    assign step_ext = {{(32 - STEP_W){1'b0}}, step_reg};
    // Wrap-safe check that now has reached the stored deadline.
    assign diff_now = now_reg - deadline_reg;
    assign reached  = !diff_now[31];

    assign head_inc = (head_reg == LAST_ADDR) ? '0 : head_reg + AW'(1);

    assign head_x = {{(XW - AW){1'b0}}, head_reg};
    assign col_x  = {{(XW - 5){1'b0}}, col_reg};
    assign fill_x = {{(XW - FW){1'b0}}, fill_reg};
    assign col_valid = col_x < fill_x;
    // Column 0 is the newest bar, stored at the ring head; older bars sit behind it.
    assign read_addr_x = (head_x >= col_x) ? head_x - col_x : head_x + BARS_X - col_x;

    assign level_clamped = (level_in_reg > {1'b0, FULL_LEVEL}) ? FULL_LEVEL
                                                               : level_in_reg[LEVEL_W-1:0];

    assign fill_wide = {{FILLED_W{1'b0}}, fill_reg};

    tlhs_ram #(
        .WIDTH (LEVEL_W),
        .DEPTH (BARS)
    ) u_bar_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    tlhs_scale u_scale (
        .clk    (clk),
        .level  (ram_rdata),
        .track  (track_reg),
        .pixels (scaled)
    );

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                unique case (func_t'(func_reg))
                    FUNC_OFFER: state_next = reached ? S_ADV : S_DONE;
                    FUNC_READ:  state_next = col_valid ? S_RD : S_DONE;
                    default:    state_next = S_DONE;
                endcase
            end
            S_ADV:  state_next = S_DONE;
            S_RD:   state_next = S_MUL;
            S_MUL:  state_next = S_DIVQ;
            S_DIVQ: state_next = S_DONE;
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Datapath and memory control for each state.
    always_comb
    begin
        head_next      = head_reg;
        fill_next      = fill_reg;
        deadline_next  = deadline_reg;
        res_ok_next    = res_ok_reg;
        res_level_next = res_level_reg;
        res_pix_next   = res_pix_reg;
        ram_we         = 1'b0;
        ram_waddr      = head_inc;
        ram_wdata      = level_clamped;
        ram_re         = 1'b0;
        ram_raddr      = read_addr_x[AW-1:0];
        out_valid_next = out_valid_reg;

        if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end

        unique case (state_reg)
            S_EXEC:
            begin
                res_ok_next    = 1'b0;
                res_level_next = '0;
                res_pix_next   = '0;
                unique case (func_t'(func_reg))
                    FUNC_RESET:
                    begin
                        fill_next     = '0;
                        deadline_next = now_reg + step_ext;
                        res_ok_next   = 1'b1;
                    end
                    FUNC_OFFER:
                    begin
                        if (reached)
                        begin
                            ram_we        = 1'b1;
                            head_next     = head_inc;
                            if (fill_reg != FULL_FILL)
                            begin
                                fill_next = fill_reg + FW'(1);
                            end
                            deadline_next = deadline_reg + step_ext;
                            res_ok_next   = 1'b1;
                        end
                    end
                    FUNC_READ:
                    begin
                        ram_re = col_valid;
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_ADV:
            begin
                // One or more whole steps were missed: restart from now.
                if (reached)
                begin
                    deadline_next = now_reg + step_ext;
                end
            end
            S_DIVQ:
            begin
                res_ok_next    = 1'b1;
                res_level_next = ram_rdata;
                res_pix_next   = scaled;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= STEP_RESET;
            track_reg     <= TRACK_RESET;
            head_reg      <= '0;
            fill_reg      <= '0;
            deadline_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            fill_reg      <= fill_next;
            deadline_reg  <= deadline_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_STEP_INTERVAL: step_reg  <= cfg_wdata[STEP_W-1:0];
                    CFG_TRACK_HEIGHT:  track_reg <= cfg_wdata[TRACK_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        res_ok_reg    <= res_ok_next;
        res_level_reg <= res_level_next;
        res_pix_reg   <= res_pix_next;
        if (in_fire)
        begin
            func_reg     <= s_axis_tuser;
            now_reg      <= s_axis_tdata[31:0];
            level_in_reg <= s_axis_tdata[39:32];
            col_reg      <= s_axis_tdata[44:40];
        end
        if (load_out)
        begin
            out_ok_reg     <= res_ok_reg;
            out_level_reg  <= res_level_reg;
            out_pix_reg    <= res_pix_reg;
            out_filled_reg <= fill_wide[FILLED_W-1:0];
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_ok_reg;
    assign m_axis_tdata  = {1'b0, out_filled_reg, out_pix_reg, out_level_reg};

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the timed level history strip.
module tb_top;
    import tlhs_pkg::*;

    localparam int NUM_BARS = 32;

    // One input item, as carried on the slave-side stream.
    typedef struct packed {
        func_t       func;
        logic [31:0] now;
        logic [7:0]  level;
        logic [4:0]  column;
    } strip_item_t;

    // One result item, as carried on the master-side stream.
    typedef struct packed {
        logic                ok;
        logic [LEVEL_W-1:0]  level;
        logic [TRACK_W-1:0]  pixels;
        logic [FILLED_W-1:0] filled;
    } strip_result_t;

    // A row of the directed table. Where typed is set, want is the result that can be
    // read straight off the behavior; every other row goes through the predictor.
    typedef struct packed {
        strip_item_t   item;
        logic          typed;
        strip_result_t want;
    } strip_row_t;

    localparam strip_result_t NO_TYPED = '0;
    localparam int DIRECTED_ROWS = 22;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [47:0]         s_axis_tdata = '0;
    logic [1:0]          s_axis_tuser = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [23:0]         m_axis_tdata;
    logic                m_axis_tuser;
    logic                cfg_we = 1'b0;
    logic                cfg_index = 1'b0;
    logic [CFG_W-1:0]    cfg_wdata = '0;

    // Shadow copy of the strip, as the predictor sees it.
    logic [LEVEL_W-1:0]  held_bars [NUM_BARS];
    int                  held_count;
    logic [31:0]         due_time;
    logic [STEP_W-1:0]   step_ms;
    logic [TRACK_W-1:0]  track_px;

    // Results still owed by the block, oldest first.
    strip_result_t       awaited_results [$];
    int                  errors = 0;

    // When set, the matching side never idles, which gives stretches at full rate.
    bit                  calm_tx = 1'b0;
    bit                  calm_rx = 1'b0;
    int                  rx_stall_left = 0;

    strip_row_t          directed_rows [DIRECTED_ROWS];

    timed_level_history_strip_top #(
        .BARS(NUM_BARS)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    always #5 clk = ~clk;

    // A generous bound: the slowest legal run, with every gap and stall at its longest,
    // stays far below this.
    initial
    begin
        #5_000_000;
        $display("tb_top: FAIL");
        $finish;
    end

    // The deadline counts as reached when the wrapping difference now - due is not negative.
    function automatic bit due_reached(logic [31:0] now, logic [31:0] due);
        logic [31:0] diff;
        diff = now - due;
        return !diff[31];
    endfunction

    // Applies one item to the shadow strip and returns the result it must produce.
    function automatic strip_result_t predict_strip(strip_item_t it);
        strip_result_t      r;
        logic [LEVEL_W-1:0] lv;
        int                 prod;
        r = '0;
        case (it.func)
            FUNC_RESET:
            begin
                for (int i = 0; i < NUM_BARS; i++)
                begin
                    held_bars[i] = '0;
                end
                held_count = 0;
                due_time = it.now + 32'(step_ms);
                r.ok = 1'b1;
            end
            FUNC_OFFER:
            begin
                if (due_reached(it.now, due_time))
                begin
                    lv = (it.level > 8'(FULL_LEVEL)) ? FULL_LEVEL : it.level[LEVEL_W-1:0];
                    for (int i = NUM_BARS - 1; i > 0; i--)
                    begin
                        held_bars[i] = held_bars[i-1];
                    end
                    held_bars[0] = lv;
                    if (held_count < NUM_BARS)
                    begin
                        held_count++;
                    end
                    // Advance by one step; if that step has already passed too, the
                    // schedule restarts from now instead of trying to catch up.
                    due_time = due_time + 32'(step_ms);
                    if (due_reached(it.now, due_time))
                    begin
                        due_time = it.now + 32'(step_ms);
                    end
                    r.ok = 1'b1;
                end
            end
            FUNC_READ:
            begin
                if (int'(it.column) < held_count)
                begin
                    lv = held_bars[it.column];
                    r.ok = 1'b1;
                    r.level = lv;
                    // Rounded scaling, but a nonzero level never shows as an empty bar unless the track is zero.
                    if (track_px != '0 && lv != '0)
                    begin
                        prod = (int'(track_px) * int'(lv) + 50) / 100;
                        if (prod < 1)
                        begin
                            prod = 1;
                        end
                        r.pixels = prod[TRACK_W-1:0];
                    end
                end
            end
            default:
            begin
            end
        endcase
        r.filled = held_count[FILLED_W-1:0];
        return r;
    endfunction

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
        begin
            return 0;
        end
        else if (r < 90)
        begin
            return $urandom_range(1, 3);
        end
        else if (r < 97)
        begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 60);
    endfunction

    // Levels lean on the clamp boundary and on zero.
    function automatic logic [7:0] pick_level();
        case ($urandom_range(0, 7))
            0: return 8'd0;
            1: return 8'd100;
            2: return 8'd101;
            3: return 8'd255;
            4: return 8'($urandom_range(1, 99));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Called just after a falling edge; returns just after a later falling edge.
    task automatic write_register(logic idx, logic [CFG_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
        if (idx == CFG_STEP_INTERVAL)
        begin
            step_ms = val[STEP_W-1:0];
        end
        else
        begin
            track_px = val[TRACK_W-1:0];
        end
    endtask

    // Offers one item, holds it until the block takes it, and records what it owes.
    // Called just after a falling edge; returns just after a later falling edge.
    task automatic send_item(strip_item_t it, logic typed, strip_result_t want);
        int            gap;
        strip_result_t predicted;
        gap = calm_tx ? 0 : pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {3'b000, it.column, it.level, it.now};
        s_axis_tuser <= it.func;
        do
        begin
            @(posedge clk);
        end
        while (!s_axis_tready);
        predicted = predict_strip(it);
        awaited_results.push_back(typed ? want : predicted);
        @(negedge clk);
    endtask

    // Stops sending, waits for every owed result, then lets the pipeline settle.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (awaited_results.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (10) @(negedge clk);
    endtask

    // Random items. Offers mostly land on or just past the deadline so that the schedule
    // keeps moving, with early, late, far and wrap-boundary times mixed in.
    task automatic run_random(int count, int reset_pct);
        strip_item_t it;
        int          r;
        int          top_col;
        for (int n = 0; n < count; n++)
        begin
            r = $urandom_range(0, 99);
            it.level = pick_level();
            it.column = 5'($urandom);
            it.now = $urandom;
            if (r < reset_pct)
            begin
                it.func = FUNC_RESET;
                if ($urandom_range(0, 1) == 0)
                begin
                    it.now = due_time + 32'($urandom_range(0, 5000));
                end
            end
            else if (r < reset_pct + 4)
            begin
                it.func = FUNC_NONE;
            end
            else if (r < 55)
            begin
                it.func = FUNC_OFFER;
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5: it.now = due_time + 32'($urandom_range(0, 3));
                    6: it.now = due_time - 32'($urandom_range(1, 5));
                    7: it.now = due_time + step_ms * 32'($urandom_range(1, 4))
                                + 32'($urandom_range(0, 2));
                    8: it.now = $urandom;
                    default: it.now = due_time + (($urandom_range(0, 1) == 0)
                                ? 32'h7FFF_FFFF : 32'h8000_0000);
                endcase
            end
            else
            begin
                it.func = FUNC_READ;
                if (held_count > 0 && $urandom_range(0, 9) < 7)
                begin
                    top_col = (held_count > 31) ? 31 : held_count;
                    it.column = 5'($urandom_range(0, top_col));
                end
            end
            send_item(it, 1'b0, NO_TYPED);
            // Now and then the sender holds off until everything owed has come back.
            if ($urandom_range(0, 199) == 0)
            begin
                drain_results();
            end
        end
    endtask

    // The receiver stalls at random except during calm stretches.
    always @(negedge clk)
    begin
        if (rx_stall_left > 0)
        begin
            rx_stall_left = rx_stall_left - 1;
            m_axis_tready <= 1'b0;
        end
        else if (!calm_rx && $urandom_range(0, 3) == 0)
        begin
            rx_stall_left = pick_gap();
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= 1'b1;
        end
    end

    // Every accepted result is compared field by field with the oldest one owed.
    always @(posedge clk)
    begin
        strip_result_t got;
        strip_result_t exp_r;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.ok = m_axis_tuser;
            got.level = m_axis_tdata[6:0];
            got.pixels = m_axis_tdata[16:7];
            got.filled = m_axis_tdata[22:17];
            if (awaited_results.size() == 0)
            begin
                errors++;
                $display("%0t: result item with none owed: ok %0d level %0d pixels %0d filled %0d",
                         $time, got.ok, got.level, got.pixels, got.filled);
            end
            else
            begin
                exp_r = awaited_results.pop_front();
                if (got.ok !== exp_r.ok)
                begin
                    errors++;
                    $display("%0t: ok expected %0d, actual %0d", $time, exp_r.ok, got.ok);
                end
                if (got.level !== exp_r.level)
                begin
                    errors++;
                    $display("%0t: bar_level expected %0d, actual %0d",
                             $time, exp_r.level, got.level);
                end
                if (got.pixels !== exp_r.pixels)
                begin
                    errors++;
                    $display("%0t: bar_pixels expected %0d, actual %0d",
                             $time, exp_r.pixels, got.pixels);
                end
                if (got.filled !== exp_r.filled)
                begin
                    errors++;
                    $display("%0t: filled expected %0d, actual %0d",
                             $time, exp_r.filled, got.filled);
                end
            end
        end
    end

    initial
    begin
        logic [STEP_W-1:0]  phase_step;
        logic [TRACK_W-1:0] phase_track;
        int                 reset_pct;

        // Directed rows run at the register reset values: a step of 1000 and a zero track,
        // so every read here also shows that a zero track gives zero heights.
        directed_rows = '{
            // Read of an empty strip after reset.
            '{'{FUNC_READ,  32'd0,           8'd0,   5'd0},  1'b1, '{1'b0, 7'd0, 10'd0, 6'd0}},
            // Unused code with every field at its top value changes nothing.
            '{'{FUNC_NONE,  32'hFFFF_FFFF,   8'd255, 5'd31}, 1'b1, '{1'b0, 7'd0, 10'd0, 6'd0}},
            // The deadline starts at zero, so an offer at time zero is taken and clamped.
            '{'{FUNC_OFFER, 32'd0,           8'd255, 5'd0},  1'b1, '{1'b1, 7'd0, 10'd0, 6'd1}},
            // Early offer, exact-deadline offer, and one after several missed steps.
            '{'{FUNC_OFFER, 32'd500,         8'd50,  5'd0},  1'b0, NO_TYPED},
            '{'{FUNC_OFFER, 32'd1000,        8'd0,   5'd0},  1'b0, NO_TYPED},
            '{'{FUNC_OFFER, 32'd5000,        8'd101, 5'd0},  1'b0, NO_TYPED},
            '{'{FUNC_OFFER, 32'd5999,        8'd7,   5'd0},  1'b0, NO_TYPED},
            '{'{FUNC_OFFER, 32'd6000,        8'd100, 5'd0},  1'b0, NO_TYPED},
            '{'{FUNC_READ,  32'd0,           8'd0,   5'd0},  1'b0, NO_TYPED},
            '{'{FUNC_READ,  32'd0,           8'd0,   5'd1},  1'b0, NO_TYPED},
            '{'{FUNC_READ,  32'd0,           8'd0,   5'd3},  1'b0, NO_TYPED},
            // First column at the fill count, and the last column.
            '{'{FUNC_READ,  32'd0,           8'd0,   5'd4},  1'b0, NO_TYPED},
            '{'{FUNC_READ,  32'hFFFF_FFFF,   8'd255, 5'd31}, 1'b0, NO_TYPED},
            // Strip reset near the top of time, so the deadline wraps past zero.
            '{'{FUNC_RESET, 32'hFFFF_FF00,   8'd0,   5'd0},  1'b1, '{1'b1, 7'd0, 10'd0, 6'd0}},
            '{'{FUNC_OFFER, 32'hFFFF_FFFF,   8'd1,   5'd0},  1'b0, NO_TYPED},
            '{'{FUNC_OFFER, 32'h0000_02E8,   8'd1,   5'd0},  1'b0, NO_TYPED},
            // Half a wrap ahead still counts as reached, and time zero then lies just under
            // half a wrap past the restarted deadline.
            '{'{FUNC_OFFER, 32'h8000_06CF,   8'd100, 5'd0},  1'b0, NO_TYPED},
            '{'{FUNC_OFFER, 32'h0000_0000,   8'd30,  5'd0},  1'b0, NO_TYPED},
            '{'{FUNC_READ,  32'd0,           8'd0,   5'd0},  1'b0, NO_TYPED},
            '{'{FUNC_NONE,  32'd0,           8'd0,   5'd0},  1'b0, NO_TYPED},
            // A strip reset empties the strip, so a read of column 0 is refused.
            '{'{FUNC_RESET, 32'd0,           8'd0,   5'd0},  1'b1, '{1'b1, 7'd0, 10'd0, 6'd0}},
            '{'{FUNC_READ,  32'd0,           8'd0,   5'd0},  1'b1, '{1'b0, 7'd0, 10'd0, 6'd0}}
        };

        for (int i = 0; i < NUM_BARS; i++)
        begin
            held_bars[i] = '0;
        end
        held_count = 0;
        due_time = '0;
        step_ms = STEP_RESET;
        track_px = TRACK_RESET;

        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int i = 0; i < DIRECTED_ROWS; i++)
        begin
            send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);
        end
        drain_results();

        // Each phase rewrites both registers while the block is idle, then runs random
        // items. The settings cover both extremes of each register, a zero step, and
        // track writes whose unused upper bits are random.
        for (int p = 0; p < 8; p++)
        begin
            reset_pct = 4;
            calm_tx = 1'b0;
            calm_rx = 1'b0;
            case (p)
                0:
                begin
                    phase_step = 20'd1;
                    phase_track = 10'd1023;
                    reset_pct = 0;
                    calm_tx = 1'b1;
                    calm_rx = 1'b1;
                end
                1:
                begin
                    phase_step = 20'd1000000;
                    phase_track = 10'd1;
                end
                2:
                begin
                    phase_step = 20'd0;
                    phase_track = 10'd512;
                    reset_pct = 1;
                end
                3:
                begin
                    phase_step = 20'd1000;
                    phase_track = 10'd100;
                    calm_rx = 1'b1;
                end
                4:
                begin
                    phase_step = 20'($urandom_range(1, 1000000));
                    phase_track = 10'($urandom);
                end
                5:
                begin
                    phase_step = 20'd3;
                    phase_track = 10'd0;
                    calm_tx = 1'b1;
                end
                6:
                begin
                    phase_step = 20'($urandom_range(1, 50));
                    phase_track = 10'($urandom);
                    reset_pct = 2;
                end
                default:
                begin
                    phase_step = 20'hFFFFF;
                    phase_track = 10'd1023;
                    reset_pct = 0;
                end
            endcase
            write_register(CFG_STEP_INTERVAL, phase_step);
            write_register(CFG_TRACK_HEIGHT, {10'($urandom), phase_track});
            run_random(125, reset_pct);
            drain_results();
        end

        if (errors == 0)
        begin
            $display("tb_top: PASS");
        end
        else
        begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule
